[sv/skms_pkg.sv]
package skms_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 64;

  // Fixed field widths of the stream items
  localparam int ITEM_W     = 64;
  localparam int INDEX_W    = 11;
  localparam int COUNT_W    = 16;
  localparam int OUT_DATA_W = 32;

  // Command codes carried in s_tuser
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Sequencer commands to the probe unit
  typedef struct packed {
    logic start;
    logic probe;
  } probe_ctrl_t;

  // Probe unit status back to the sequencer
  typedef struct packed {
    logic more;
    logic tail;
    logic equal;
  } probe_stat_t;

endpackage

[sv/sorted_key_match_search_core.sv]
// Channel | Dir | tdata (low bit up)                          | tuser         | tlast
// s_*     | in  | item_value[63:0]                            | command       | group_last
// m_*     | out | match_index[10:0], match_count[26:11], 0s  | found         | -
//
// A search issues the first read at the midpoint of its range, then runs probe
// steps that halve the range (one read of the table RAM and one signed compare
// each), then one equality check when the final position lies inside the table,
// then posts the result. An empty range posts with no probe steps.
// Reset clears the counters, bound and output register; the table is not cleared.
// A result waiting on m_tready holds the sequencer in its final state; appends
// and a new search are still taken while an earlier result is held.
module sorted_key_match_search_core #(
  parameter int TABLE_DEPTH = skms_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = skms_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [skms_pkg::ITEM_W-1:0]     s_tdata,  // item_value
  input  logic                            s_tuser,  // command
  input  logic                            s_tlast,  // group_last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [skms_pkg::OUT_DATA_W-1:0] m_tdata,  // match_index, match_count, zero pad
  output logic                            m_tuser   // found
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  skms_pkg::state_t      state;
  skms_pkg::state_t      state_next;
  skms_pkg::probe_ctrl_t ctrl;
  skms_pkg::probe_stat_t stat;

  logic [CW-1:0]                   entry_count;
  logic [AW-1:0]                   lower_bound;
  logic [skms_pkg::COUNT_W-1:0]    hits;
  logic                            hit;
  logic                            last;

  logic                            accept;
  logic                            ram_we;
  logic                            out_free;
  logic                            post;
  logic [AW-1:0]                   raddr;
  logic [AW-1:0]                   lo_idx;
  logic [VALUE_WIDTH-1:0]          rdata;
  logic [AW+skms_pkg::INDEX_W-1:0] idx_wide;
  logic [skms_pkg::INDEX_W-1:0]    idx_out;
  logic [skms_pkg::COUNT_W-1:0]    hits_inc;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      skms_pkg::ST_IDLE: begin
        if (accept && s_tuser == skms_pkg::CMD_SEARCH) begin
          if (CW'(lower_bound) < entry_count) begin
            state_next = skms_pkg::ST_PROBE;
          end else begin
            state_next = skms_pkg::ST_DONE;
          end
        end
      end
      skms_pkg::ST_PROBE: begin
        if (!stat.more) begin
          state_next = stat.tail ? skms_pkg::ST_CHECK : skms_pkg::ST_DONE;
        end
      end
      skms_pkg::ST_CHECK: begin
        state_next = skms_pkg::ST_DONE;
      end
      skms_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = skms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = skms_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready   = state == skms_pkg::ST_IDLE;
    ctrl.start = state == skms_pkg::ST_IDLE && s_tvalid && s_tuser == skms_pkg::CMD_SEARCH;
    ctrl.probe = state == skms_pkg::ST_PROBE;
    ram_we     = accept && s_tuser == skms_pkg::CMD_APPEND &&
                 entry_count < CW'(TABLE_DEPTH);
    post       = state == skms_pkg::ST_DONE && out_free;
  end

  // Result fields
  always_comb begin
    idx_wide = {{skms_pkg::INDEX_W{1'b0}}, lo_idx};
    idx_out  = hit ? idx_wide[skms_pkg::INDEX_W-1:0] : '1;
    hits_inc = (hit && hits != '1) ? hits + 1'b1 : hits;
  end

  skms_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[AW-1:0]),
    .wdata (s_tdata[VALUE_WIDTH-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  skms_probe #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_probe (
    .clk         (clk),
    .ctrl        (ctrl),
    .key_in      (s_tdata[VALUE_WIDTH-1:0]),
    .lower_bound (lower_bound),
    .entry_count (entry_count),
    .rdata       (rdata),
    .raddr       (raddr),
    .lo_idx      (lo_idx),
    .stat        (stat)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the search flags
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      hit  <= 1'b0;
      last <= s_tlast;
    end else if (state == skms_pkg::ST_CHECK) begin
      hit <= stat.equal;
    end
  end

  // Fill count, bound and match count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      lower_bound <= '0;
      hits        <= '0;
    end else if (ram_we) begin
      entry_count <= entry_count + 1'b1;
    end else if (post) begin
      if (last) begin
        entry_count <= '0;
        lower_bound <= '0;
        hits        <= '0;
      end else begin
        hits <= hits_inc;
        if (hit) begin
          lower_bound <= lo_idx;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (post) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      m_tuser <= hit;
      m_tdata <= skms_pkg::OUT_DATA_W'({hits_inc, idx_out});
    end
  end

  // A miss always carries index -1
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[skms_pkg::INDEX_W-1:0] == '1)
    else $error("miss result without index -1");

  // The fill count never passes the table depth
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The bound stays inside the loaded entries
  assert property (@(posedge clk) disable iff (rst)
    lower_bound == '0 || CW'(lower_bound) < entry_count)
    else $error("lower bound outside loaded range");

  // A posted hit carries the count just raised
  assert property (@(posedge clk) disable iff (rst)
    post && hit && !last && hits != '1 |=> hits == $past(hits) + 1'b1)
    else $error("match count not advanced on hit");

endmodule

[sv/skms_ram.sv]
module skms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/skms_probe.sv]
module skms_probe #(
  parameter int TABLE_DEPTH = skms_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = skms_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  skms_pkg::probe_ctrl_t          ctrl,
  input  logic [VALUE_WIDTH-1:0]         key_in,
  input  logic [$clog2(TABLE_DEPTH)-1:0] lower_bound,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count,
  input  logic [VALUE_WIDTH-1:0]         rdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] raddr,
  output logic [$clog2(TABLE_DEPTH)-1:0] lo_idx,
  output skms_pkg::probe_stat_t          stat
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] key;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [AW-1:0]          pmid;

  logic          less;
  logic [CW-1:0] lb_ext;
  logic [CW-1:0] lo_next;
  logic [CW-1:0] hi_next;
  logic [CW-1:0] start_mid;
  logic [CW-1:0] next_mid;

  // Narrow the range around the entry just read
  always_comb begin
    less      = $signed(rdata) < $signed(key);
    lb_ext    = CW'(lower_bound);
    lo_next   = less ? (CW'(pmid) + CW'(1)) : lo;
    hi_next   = less ? hi : CW'(pmid);
    start_mid = lb_ext + ((entry_count - lb_ext) >> 1);
    next_mid  = lo_next + ((hi_next - lo_next) >> 1);
  end

  // Pick the next read address: first midpoint, next midpoint, or final position
  always_comb begin
    if (ctrl.start) begin
      raddr = start_mid[AW-1:0];
    end else if (lo_next < hi_next) begin
      raddr = next_mid[AW-1:0];
    end else begin
      raddr = lo_next[AW-1:0];
    end
  end

  // Report loop status and the final equality test
  always_comb begin
    stat.more  = lo_next < hi_next;
    stat.tail  = lo_next < entry_count;
    stat.equal = rdata == key;
  end

  assign lo_idx = lo[AW-1:0];

  // Load the range on start, then step it once per probe
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      key  <= key_in;
      lo   <= lb_ext;
      hi   <= entry_count;
      pmid <= start_mid[AW-1:0];
    end else if (ctrl.probe) begin
      lo   <= lo_next;
      hi   <= hi_next;
      pmid <= raddr;
    end
  end

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_W      = skms_pkg::ITEM_W;
  localparam int INDEX_W     = skms_pkg::INDEX_W;
  localparam int COUNT_W     = skms_pkg::COUNT_W;
  localparam int OUT_DATA_W  = skms_pkg::OUT_DATA_W;
  localparam int DEPTH       = skms_pkg::TABLE_DEPTH_DEF;
  localparam int VALUE_W     = skms_pkg::VALUE_WIDTH_DEF;
  localparam int KEY_BASE    = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 400;

  localparam logic signed [ITEM_W-1:0] V_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [ITEM_W-1:0] V_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [INDEX_W-1:0]       NOT_FOUND = '1;
  localparam logic [COUNT_W-1:0]       COUNT_TOP = '1;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } match_t;

  // typed = 1: the row carries its own expected match
  typedef struct packed {
    logic              cmd;
    logic [ITEM_W-1:0] value;
    logic              last;
    logic              typed;
    match_t            want;
  } item_t;

  localparam match_t NO_WANT = '0;

  // Directed rows: empty table, extremes, duplicates, key below bound,
  // group end, ignored last on append, unsorted table
  localparam item_t DIRECTED [24] = '{
    '{skms_pkg::CMD_SEARCH, 64'd0,      1'b0, 1'b1, '{1'b0, NOT_FOUND, 16'd0}},
    '{skms_pkg::CMD_SEARCH, V_MAX,      1'b1, 1'b1, '{1'b0, NOT_FOUND, 16'd0}},
    '{skms_pkg::CMD_APPEND, V_MIN,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, -64'sd5,    1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, 64'd0,      1'b1, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, 64'd7,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, 64'd7,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, V_MAX,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, V_MIN,      1'b0, 1'b1, '{1'b1, 11'd0, 16'd1}},
    '{skms_pkg::CMD_SEARCH, -64'sd6,    1'b0, 1'b1, '{1'b0, NOT_FOUND, 16'd1}},
    '{skms_pkg::CMD_SEARCH, 64'd7,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, 64'd7,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, -64'sd5,    1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, V_MAX,      1'b1, 1'b1, '{1'b1, 11'd5, 16'd4}},
    '{skms_pkg::CMD_SEARCH, V_MIN,      1'b0, 1'b1, '{1'b0, NOT_FOUND, 16'd0}},
    '{skms_pkg::CMD_APPEND, 64'd9,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, 64'd3,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, -64'sd1,    1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, 64'd3,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, 64'd9,      1'b0, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, -64'sd1,    1'b1, 1'b0, NO_WANT},
    '{skms_pkg::CMD_APPEND, -64'sd1,    1'b1, 1'b0, NO_WANT},
    '{skms_pkg::CMD_SEARCH, -64'sd1,    1'b0, 1'b1, '{1'b1, 11'd0, 16'd1}},
    '{skms_pkg::CMD_SEARCH, -64'sd1,    1'b1, 1'b1, '{1'b1, 11'd0, 16'd2}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [ITEM_W-1:0]     s_tdata = '0;
  logic                  s_tuser = skms_pkg::CMD_APPEND;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // Shadow of the block state
  logic signed [ITEM_W-1:0] shadow_table [DEPTH];
  int                       shadow_fill = 0;
  int                       shadow_bound = 0;
  logic [COUNT_W-1:0]       shadow_hits = '0;

  item_t  item_queue [$];
  match_t pending_matches [$];
  item_t  on_wire;
  logic signed [ITEM_W-1:0] pool [KEY_BASE + 64];

  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_hits = 0;
  int errors = 0;
  int src_wait = 0;
  int sink_wait = 0;
  int quiet = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;

  sorted_key_match_search_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one accepted item to the shadow state; return 1 with the match on a search
  function automatic bit predict_lookup(input item_t it, output match_t res);
    logic signed [ITEM_W-1:0] key;
    int lo;
    int hi;
    int mid;
    bit hit;
    key = $signed(it.value << (ITEM_W - VALUE_W)) >>> (ITEM_W - VALUE_W);
    res = '0;
    if (it.cmd == skms_pkg::CMD_APPEND) begin
      if (shadow_fill < DEPTH) begin
        shadow_table[shadow_fill] = key;
        shadow_fill++;
      end
      return 1'b0;
    end
    hit = 1'b0;
    lo = shadow_bound;
    hi = shadow_fill;
    if (shadow_fill > 0 && shadow_bound < shadow_fill) begin
      // lowest position in range whose entry is not below the key
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (shadow_table[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      if (lo < shadow_fill && shadow_table[lo] == key) hit = 1'b1;
    end
    if (hit) begin
      shadow_bound = lo;
      if (shadow_hits != COUNT_TOP) shadow_hits++;
    end
    res.found = hit;
    res.index = hit ? INDEX_W'(lo) : NOT_FOUND;
    res.count = shadow_hits;
    if (it.last) begin
      shadow_bound = 0;
      shadow_hits = '0;
      shadow_fill = 0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [ITEM_W-1:0] pick_value();
    logic signed [ITEM_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = V_MIN;
      1: v = V_MAX;
      2, 3, 4: begin
        v = $urandom_range(0, 32);
        v = v - 16;
      end
      5: v = -1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic queue_op(input logic cmd, input logic [ITEM_W-1:0] value, input logic last);
    item_t it;
    it = '{cmd, value, last, 1'b0, NO_WANT};
    item_queue.push_back(it);
    n_pushed++;
  endtask

  // Ascending insertion sort of pool[lo .. hi-1]
  task automatic sort_span(input int lo, input int hi);
    logic signed [ITEM_W-1:0] v;
    int j;
    for (int i = lo + 1; i < hi; i++) begin
      v = pool[i];
      j = i - 1;
      while (j >= lo && pool[j] > v) begin
        pool[j + 1] = pool[j];
        j--;
      end
      pool[j + 1] = v;
    end
  endtask

  // One key group: appends (plus appends past a full table), then searches
  task automatic build_group(input int n_app, input int n_key, input bit tidy,
                             input bit close, input bit wide, input int overflow);
    for (int i = 0; i < n_app; i++) pool[i] = wide ? {$urandom, $urandom} : pick_value();
    if (tidy) sort_span(0, n_app);
    for (int i = 0; i < n_app; i++)
      queue_op(skms_pkg::CMD_APPEND, pool[i], 1'($urandom_range(0, 1)));
    for (int i = 0; i < overflow; i++) queue_op(skms_pkg::CMD_APPEND, V_MAX, 1'b0);
    for (int j = 0; j < n_key; j++) begin
      if (n_app > 0 && $urandom_range(0, 2) != 0) pool[KEY_BASE + j] = pool[$urandom_range(0, n_app - 1)];
      else pool[KEY_BASE + j] = pick_value();
    end
    // on a full table probe the top entry and a value dropped past the end
    if (wide) begin
      pool[KEY_BASE] = pool[n_app - 1];
      pool[KEY_BASE + 1] = V_MAX;
    end
    if (tidy) sort_span(KEY_BASE, KEY_BASE + n_key);
    for (int j = 0; j < n_key; j++)
      queue_op(skms_pkg::CMD_SEARCH, pool[KEY_BASE + j],
               (close && j == n_key - 1) || (!tidy && $urandom_range(0, 15) == 0));
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (n_accepted != n_pushed || pending_matches.size() != 0);
  endtask

  // Feed items, predict on every accepted item
  always @(posedge clk) begin : item_feed
    match_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        n_accepted++;
        if (predict_lookup(on_wire, res))
          pending_matches.push_back(on_wire.typed ? on_wire.want : res);
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait > 0) begin
          src_wait <= src_wait - 1;
          s_tvalid <= 1'b0;
        end else if (item_queue.size() > 0) begin
          on_wire = item_queue.pop_front();
          s_tdata <= on_wire.value;
          s_tuser <= on_wire.cmd;
          s_tlast <= on_wire.last;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
          src_wait <= src_calm ? 0 : $urandom_range(0, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take results with random stalls and compare against the oldest prediction
  always @(posedge clk) begin : match_check
    match_t want;
    int draw;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      n_results++;
      if (m_tuser) n_hits++;
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t: unexpected item found=%0b index=%0d count=%0d", $time, m_tuser,
                 $signed(m_tdata[INDEX_W-1:0]), m_tdata[INDEX_W +: COUNT_W]);
      end else begin
        want = pending_matches.pop_front();
        if (m_tuser !== want.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, m_tuser);
        end
        if (m_tdata[INDEX_W-1:0] !== want.index) begin
          errors++;
          $display("%0t: match_index expected %0d actual %0d", $time, $signed(want.index),
                   $signed(m_tdata[INDEX_W-1:0]));
        end
        if (m_tdata[INDEX_W +: COUNT_W] !== want.count) begin
          errors++;
          $display("%0t: match_count expected %0d actual %0d", $time, want.count,
                   m_tdata[INDEX_W +: COUNT_W]);
        end
      end
      if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
      draw = sink_calm ? 0 : $urandom_range(0, 10);
      m_tready <= (draw == 0);
      sink_wait <= draw;
    end else if (!m_tready) begin
      if (sink_wait <= 1) m_tready <= 1'b1;
      sink_wait <= sink_wait - 1;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int n_rand;
    int n_app;
    int n_key;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      item_queue.push_back(DIRECTED[i]);
      n_pushed++;
    end

    // random groups: mostly sorted tables and ascending keys, some noise
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
      n_key = $urandom_range(1, 10);
      build_group(n_app, n_key, $urandom_range(0, 6) != 0, $urandom_range(0, 7) != 0, 1'b0, 0);
      n_rand += n_app + n_key;
    end

    // close any open group, then fill the table past full
    queue_op(skms_pkg::CMD_SEARCH, '0, 1'b1);
    build_group(DEPTH, 24, 1'b1, 1'b1, 1'b1, 2);
    wait_drained();

    repeat (50) @(posedge clk);
    $display("Sent %0d items and checked %0d search results, %0d of them hits,", n_accepted,
             n_results, n_hits);
    $display("over empty, duplicate, unsorted and full-table groups.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
